// File: rtl/ksrs_pkg.sv
`timescale 1ns / 1ps
// Package for the k-mer support read splitter: request and result types,
// configuration types and sizing constants. Depends on nothing.
package ksrs_pkg;

    localparam int MAX_KMERS = 256;
    localparam int POS_W = $clog2(MAX_KMERS);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int FREQ_W = 16;
    localparam int KLEN_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] LEVEL_STRONG = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUPPORT_THRESHOLD = 1'b0,
        REG_KMER_LENGTH       = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [FREQ_W-1:0] support_threshold;
        logic [KLEN_W-1:0] kmer_length;
    } cfg_t;

    typedef struct packed {
        logic [15:0] freq_forward;
        logic [15:0] freq_reverse;
        logic        simple_link;
        logic        last_kmer;
    } kmer_in_t;

    typedef struct packed {
        logic [7:0] piece_index;
        logic [7:0] piece_start;
        logic [8:0] piece_length;
        logic       piece_strong;
        logic       read_done;
        logic       seed_found;
        logic [7:0] seed_index;
    } piece_out_t;

endpackage

// File: rtl/kmer_support_read_splitter_unit.sv
`timescale 1ns / 1ps
// A k-mer request is held in the input register; its pieces reach the piece port
// through the result queue. Throughput: one k-mer per cycle while the queue has
// room; a k-mer that both splits and ends the read yields two pieces, which
// leave the four-entry queue one per cycle while piece_stall is low. Reset clears
// all read state, sets threshold 2 and k-mer length 31; no clearing pass is needed.
module kmer_support_read_splitter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ksrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ksrs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            kmer_valid,
    output logic                            kmer_stall,
    input  ksrs_pkg::kmer_in_t              kmer,
    output logic                            piece_valid,
    input  logic                            piece_stall,
    output ksrs_pkg::piece_out_t            piece
);
    import ksrs_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       room_ok;
    logic [1:0] push_cnt;
    piece_out_t push_item0;
    piece_out_t push_item1;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SUPPORT_THRESHOLD: cfg_next.support_threshold = cfg_data;
                REG_KMER_LENGTH:       cfg_next.kmer_length = cfg_data[KLEN_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.support_threshold <= FREQ_W'(2);
            cfg_reg.kmer_length       <= KLEN_W'(31);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ksrs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .kmer_valid (kmer_valid),
        .kmer_stall (kmer_stall),
        .kmer       (kmer),
        .room_ok    (room_ok),
        .push_cnt   (push_cnt),
        .push_item0 (push_item0),
        .push_item1 (push_item1)
    );

    ksrs_out_fifo u_out_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push_item0  (push_item0),
        .push_item1  (push_item1),
        .room_ok     (room_ok),
        .piece_valid (piece_valid),
        .piece_stall (piece_stall),
        .piece       (piece)
    );

`ifndef SYNTHESIS
    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> $past(kmer_valid && !kmer_stall) || $past(kmer_stall))
        else $error("pieces produced with no k-mer request in flight");
    a_two_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> push_item1.read_done && !push_item0.read_done)
        else $error("a k-mer produced two pieces without ending the read");
    a_seed_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (piece_valid && !piece.read_done) |-> !piece.seed_found && piece.seed_index == 8'd0)
        else $error("seed reported on a piece that does not end the read");
`endif

endmodule

// File: rtl/ksrs_out_fifo.sv
`timescale 1ns / 1ps
// Result queue of the read splitter: takes up to two results per cycle and
// hands out one per cycle while piece_stall is low. Depends on ksrs_pkg.
module ksrs_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  ksrs_pkg::piece_out_t push_item0,
    input  ksrs_pkg::piece_out_t push_item1,
    output logic                room_ok,
    output logic                piece_valid,
    input  logic                piece_stall,
    output ksrs_pkg::piece_out_t piece
);
    import ksrs_pkg::*;

    piece_out_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop         = piece_valid && !piece_stall;
    assign piece_valid = (count_reg != '0);
    assign piece       = mem_reg[rd_ptr_reg];
    assign room_ok     = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_item0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push_item1;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue holds more entries than its depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> room_ok)
        else $error("results pushed without room in the queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("queue count changed with no push and no pop");
`endif

endmodule

// File: rtl/ksrs_core.sv
`timescale 1ns / 1ps
// Splitting logic: input register, read state and the single pass that
// forms up to two pieces per k-mer. Depends on ksrs_pkg.
module ksrs_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ksrs_pkg::cfg_t       cfg,
    input  logic                 kmer_valid,
    output logic                 kmer_stall,
    input  ksrs_pkg::kmer_in_t   kmer,
    input  logic                 room_ok,
    output logic [1:0]           push_cnt,
    output ksrs_pkg::piece_out_t push_item0,
    output ksrs_pkg::piece_out_t push_item1
);
    import ksrs_pkg::*;

    logic             stage_valid_reg;
    logic             stage_valid_next;
    kmer_in_t         stage_item_reg;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] begin_reg;
    logic [POS_W-1:0] begin_next;
    logic [1:0]       level_reg;
    logic [1:0]       level_next;
    logic             has_strong_reg;
    logic             has_strong_next;
    logic [7:0]       emitted_reg;
    logic [7:0]       emitted_next;
    logic [POS_W-1:0] best_span_reg;
    logic [POS_W-1:0] best_span_next;
    logic [7:0]       best_piece_reg;
    logic [7:0]       best_piece_next;
    logic             best_valid_reg;
    logic             best_valid_next;

    logic             move;
    logic             accept;
    logic             fwd_ok;
    logic             rev_ok;
    logic             is_strong;
    logic             first;
    logic             eff_last;
    logic             split;
    logic [POS_W-1:0] b_begin;
    logic             b_has;
    logic [7:0]       b_emit;
    logic [POS_W-1:0] b_bspan;
    logic [7:0]       b_bpiece;
    logic             b_bvalid;
    logic [POS_W-1:0] span0;
    logic             upd0;
    logic [POS_W-1:0] span1;
    logic             upd1;
    logic             d_bvalid;
    logic [7:0]       d_bpiece;

    assign move       = stage_valid_reg && room_ok;
    assign kmer_stall = stage_valid_reg && !room_ok;
    assign accept     = kmer_valid && !kmer_stall;

    always_comb
    begin
        stage_valid_next = accept || (stage_valid_reg && !move);

        fwd_ok    = (stage_item_reg.freq_forward >= cfg.support_threshold);
        rev_ok    = (stage_item_reg.freq_reverse >= cfg.support_threshold);
        is_strong = fwd_ok && rev_ok;
        first     = (pos_reg == '0);
        eff_last  = stage_item_reg.last_kmer || (pos_reg == POS_W'(MAX_KMERS - 1));

        b_begin  = first ? '0 : begin_reg;
        b_has    = first ? 1'b0 : has_strong_reg;
        b_emit   = first ? 8'd0 : emitted_reg;
        b_bspan  = first ? '0 : best_span_reg;
        b_bpiece = first ? 8'd0 : best_piece_reg;
        b_bvalid = first ? 1'b0 : best_valid_reg;

        split = !first && !(((level_reg == LEVEL_STRONG) && is_strong)
                            || stage_item_reg.simple_link);

        span0 = pos_reg - POS_W'(1) - b_begin;
        upd0  = split && b_has && (span0 > b_bspan);

        push_item0.piece_index  = b_emit;
        push_item0.piece_start  = 8'(b_begin);
        push_item0.piece_length = 9'(span0) + 9'(cfg.kmer_length);
        push_item0.piece_strong = b_has;
        push_item0.read_done    = 1'b0;
        push_item0.seed_found   = 1'b0;
        push_item0.seed_index   = 8'd0;

        begin_next      = split ? pos_reg : b_begin;
        has_strong_next = split ? is_strong : (b_has || is_strong);
        emitted_next    = b_emit + 8'(split);
        best_span_next  = upd0 ? span0 : b_bspan;
        best_piece_next = upd0 ? b_emit : b_bpiece;
        best_valid_next = b_bvalid || upd0;

        span1    = pos_reg - begin_next;
        upd1     = has_strong_next && (span1 > best_span_next);
        d_bvalid = best_valid_next || upd1;
        d_bpiece = upd1 ? emitted_next : best_piece_next;

        push_item1.piece_index  = emitted_next;
        push_item1.piece_start  = 8'(begin_next);
        push_item1.piece_length = 9'(span1) + 9'(cfg.kmer_length);
        push_item1.piece_strong = has_strong_next;
        push_item1.read_done    = 1'b1;
        push_item1.seed_found   = d_bvalid;
        push_item1.seed_index   = d_bvalid ? d_bpiece : 8'd0;

        level_next = 2'(fwd_ok) + 2'(rev_ok);
        pos_next   = eff_last ? '0 : pos_reg + POS_W'(1);

        if (!move)
        begin
            push_cnt = 2'd0;
        end
        else
        begin
            push_cnt = 2'(split) + 2'(eff_last);
        end

        if (move && !split)
        begin
            push_item0 = push_item1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pos_reg         <= '0;
            begin_reg       <= '0;
            level_reg       <= '0;
            has_strong_reg  <= 1'b0;
            emitted_reg     <= '0;
            best_span_reg   <= '0;
            best_piece_reg  <= '0;
            best_valid_reg  <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (move)
            begin
                pos_reg        <= pos_next;
                begin_reg      <= begin_next;
                level_reg      <= level_next;
                has_strong_reg <= has_strong_next;
                emitted_reg    <= eff_last ? emitted_next + 8'd1 : emitted_next;
                best_span_reg  <= upd1 ? span1 : best_span_next;
                best_piece_reg <= d_bpiece;
                best_valid_reg <= d_bvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= kmer;
        end
    end

`ifndef SYNTHESIS
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        kmer_stall |-> stage_valid_reg)
        else $error("request stalled while the input register is empty");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (move && eff_last) |=> (pos_reg == '0))
        else $error("k-mer position not cleared at the end of a read");
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !move |=> $stable(pos_reg) && $stable(emitted_reg))
        else $error("read state changed without a k-mer being processed");
`endif

endmodule
